@@ rtl/core/ssm_pkg.sv @@
// Shared types and constants of the sorted set membership block.
package ssm_pkg;

	localparam int CAPACITY_DEF = 256;

	// Request type codes as they arrive on the request channel.
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Operation an item performs while it travels down the chain of cells.
	typedef enum logic [1:0] {
		OP_PASS  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic found;
		logic dropped;
	} rsp_t;

	// Item as it moves from one cell to the next.
	typedef struct packed {
		logic               vld;
		op_t                op;
		logic signed [31:0] value;
		logic               found;
		logic               dropped;
	} cell_item_t;

endpackage

@@ rtl/core/ssm_cell.sv @@
// One cell of the insertion chain: holds a single element and one item stage.
module ssm_cell #(
	parameter int Idx  = 0,
	parameter int CntW = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  ssm_pkg::cell_item_t item_in,
	input  logic [CntW-1:0]     cnt_in,
	output ssm_pkg::cell_item_t item_out,
	output logic [CntW-1:0]     cnt_out
);

	logic signed [31:0]  val_q;
	logic                vld_s1;
	ssm_pkg::cell_item_t item_s1;
	logic [CntW-1:0]     cnt_s1;
	ssm_pkg::cell_item_t nxt;
	logic                occupied;
	logic                store_we;

	// The item carries the element count seen at entry, so occupancy needs no valid bit.
	assign occupied = cnt_in > CntW'(Idx);

	always_comb begin
		nxt      = item_in;
		store_we = 1'b0;
		if (item_in.vld) begin
			case (item_in.op)
				ssm_pkg::OP_LOAD: begin
					if (!occupied && (cnt_in == CntW'(Idx))) begin
						// First free cell: the value settles here.
						store_we = 1'b1;
						nxt.op   = ssm_pkg::OP_PASS;
					end else if (occupied && (item_in.value < val_q)) begin
						// Keep the smaller value and push the held one to the right.
						store_we  = 1'b1;
						nxt.value = val_q;
					end
				end
				ssm_pkg::OP_QUERY: begin
					if (occupied && (val_q == item_in.value)) begin
						nxt.found = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && store_we) begin
			val_q <= item_in.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= nxt;
			cnt_s1  <= cnt_in;
		end
	end

	always_comb begin
		item_out     = item_s1;
		item_out.vld = vld_s1;
	end

	assign cnt_out = cnt_s1;

endmodule

@@ rtl/core/sorted_set_membership.sv @@
// Top level of the sorted set membership block: entry logic and the chain of cells.
// The set lives in a row of CAPACITY cells, kept in ascending order from the first
// cell. Every item (load, query, clear) enters the first cell and moves one cell
// per cycle, so an item is accepted in every cycle that the response side does not
// stall. Its response is presented at the output of the last cell, and a stalled
// response there holds the whole chain until it is taken. A load inserts by
// keeping the smaller value in each cell and passing the larger one on; a query
// collects equal matches as it passes. The element count is kept at the entry: a
// load into a full set is flagged dropped and does nothing, and a clear resets the
// count at once. Each item yields one response.
module sorted_set_membership #(
	parameter int CAPACITY = ssm_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ssm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ssm_pkg::rsp_t rsp
);

	localparam int CntW = $clog2(CAPACITY + 1);

	logic                adv;
	logic                accept;
	logic                full;
	logic [CntW-1:0]     cnt_q;
	ssm_pkg::cell_item_t entry_item;
	ssm_pkg::cell_item_t items [CAPACITY+1];
	logic [CntW-1:0]     cnts [CAPACITY+1];

	assign adv       = !items[CAPACITY].vld || !rsp_stall;
	assign req_stall = !adv;
	assign accept    = req_valid && adv;
	assign full      = cnt_q == CntW'(CAPACITY);

	always_comb begin
		entry_item.vld     = req_valid;
		entry_item.value   = req.value;
		entry_item.found   = 1'b0;
		entry_item.dropped = 1'b0;
		entry_item.op      = ssm_pkg::OP_PASS;
		case (req.req_type)
			ssm_pkg::REQ_LOAD: begin
				if (full) begin
					entry_item.dropped = 1'b1;
				end else begin
					entry_item.op = ssm_pkg::OP_LOAD;
				end
			end
			ssm_pkg::REQ_QUERY: begin
				entry_item.op = ssm_pkg::OP_QUERY;
			end
			default: begin
			end
		endcase
	end

	assign items[0] = entry_item;
	assign cnts[0]  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (req.req_type == ssm_pkg::REQ_CLEAR) begin
				cnt_q <= '0;
			end else if ((req.req_type == ssm_pkg::REQ_LOAD) && !full) begin
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ssm_cell #(
			.Idx  (i),
			.CntW (CntW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.item_in  (items[i]),
			.cnt_in   (cnts[i]),
			.item_out (items[i+1]),
			.cnt_out  (cnts[i+1])
		);
	end

	assign rsp_valid   = items[CAPACITY].vld;
	assign rsp.found   = items[CAPACITY].found;
	assign rsp.dropped = items[CAPACITY].dropped;

	a_found_dropped_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.found && rsp.dropped))
		else $error("response flags both found and dropped");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(CAPACITY))
		else $error("element count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == ssm_pkg::REQ_CLEAR)) |=> (cnt_q == '0))
		else $error("clear did not empty the set");

	a_full_load_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == ssm_pkg::REQ_LOAD) && full) |=> $stable(cnt_q))
		else $error("dropped load changed the element count");

endmodule
